@@ sv/tvfs_pkg.sv @@
// Package of the trilinear vector field sampler: widths, codes, register
// indexes and shared types. No dependencies.
`default_nettype none
package tvfs_pkg;
  localparam int unsigned GridW = 32;
  localparam int unsigned GridH = 32;
  localparam int unsigned GridD = 32;
  localparam int unsigned StoreAw = 15;
  localparam int unsigned StoreDepth = 32768;
  localparam int unsigned VoxW = 48;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_INV_X    = 3'd3,
    REG_INV_Y    = 3'd4,
    REG_INV_Z    = 3'd5
  } reg_e;

  // Per-axis result of the grid mapping.
  typedef struct packed {
    logic        fail;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] wgt;
  } axis_t;

  // Control carried along the sampling stages.
  typedef struct packed {
    logic       last;
    logic       fail;
    logic [2:0] corner;
  } samp_ctl_t;
endpackage
`default_nettype wire

@@ sv/trilinear_vector_field_sampler_unit.sv @@
// Top level of the trilinear vector field sampler.
// Depends on tvfs_pkg, tvfs_axis_map, tvfs_ram and tvfs_blend.
//
// Usage: in_valid_i/in_stall_o carry requests. A load request (op 0)
// writes one 48-bit voxel and gives no result. A query request (op 1)
// maps the point per axis as (point - origin) * inv_step, then reads the
// eight corner voxels from the single-port voxel RAM, one per cycle while
// the datapath is not frozen, and blends them. A query therefore holds the
// block through its mapping and corner phases, and its result appears on
// out_valid_o after the blend. Points outside the grid give zero and failed.
// The configuration port (cfg_valid_i/cfg_ready_o) writes the six
// registers by index; unknown indexes are ignored. Write it only while idle.
// Reset clears the registers to origin 0 and step 1.0; the voxel RAM is
// not cleared and reads of unwritten voxels are undefined.
// When out_stall_i is high while a finished result waits, the whole
// datapath freezes; the result stays in the output register and nothing
// is lost or repeated.
`default_nettype none
module trilinear_vector_field_sampler_unit #(
  parameter int unsigned GRID_W = tvfs_pkg::GridW,
  parameter int unsigned GRID_H = tvfs_pkg::GridH,
  parameter int unsigned GRID_D = tvfs_pkg::GridD
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        op_i,
  input  wire logic [14:0]                 voxel_index_i,
  input  wire logic [15:0]                 load_x_i,
  input  wire logic [15:0]                 load_y_i,
  input  wire logic [15:0]                 load_z_i,
  input  wire logic [31:0]                 point_x_i,
  input  wire logic [31:0]                 point_y_i,
  input  wire logic [31:0]                 point_z_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [15:0]                      flow_x_o,
  output logic [15:0]                      flow_y_o,
  output logic [15:0]                      flow_z_o,
  output logic                             failed_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [tvfs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i
);
  import tvfs_pkg::*;

  logic [31:0] org_x_q, org_y_q, org_z_q, inv_x_q, inv_y_q, inv_z_q;
  logic        en;
  logic        accept;
  logic [2:0]  map_v_q;
  logic        busy_q;
  logic [2:0]  corner_q;
  logic        samp_v_q;
  samp_ctl_t   samp_ctl_q;
  axis_t       ax_x, ax_y, ax_z;
  axis_t       hx_q, hy_q, hz_q;
  logic        any_fail;
  logic [7:0]  cx, cy, cz;
  logic [31:0] lin;
  logic        ram_we;
  logic [StoreAw-1:0] ram_addr;
  logic [47:0] ram_rdata;
  logic        blend_v;
  logic [15:0] fwx_q, fwy_q, fwz_q;
  logic [47:0] ram_hold_q;
  logic        en_q;
  logic [47:0] ram_rdata_h;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0; org_y_q <= '0; org_z_q <= '0;
      inv_x_q <= 32'd65536; inv_y_q <= 32'd65536; inv_z_q <= 32'd65536;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_ORIGIN_X: org_x_q <= cfg_data_i;
        REG_ORIGIN_Y: org_y_q <= cfg_data_i;
        REG_ORIGIN_Z: org_z_q <= cfg_data_i;
        REG_INV_X:    inv_x_q <= cfg_data_i;
        REG_INV_Y:    inv_y_q <= cfg_data_i;
        REG_INV_Z:    inv_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The datapath advances unless a finished result is held.
  assign en = !(out_valid_o && out_stall_i);
  // One query at a time is in the mapping or corner phase.
  assign in_stall_o = !en || busy_q;
  assign accept = in_valid_i && !in_stall_o;

  // Axis mapping pipelines.
  tvfs_axis_map #(.N(GRID_W)) u_map_x (
    .clk_i, .en_i(en), .point_i(point_x_i), .origin_i(org_x_q),
    .inv_i(inv_x_q), .axis_o(ax_x));
  tvfs_axis_map #(.N(GRID_H)) u_map_y (
    .clk_i, .en_i(en), .point_i(point_y_i), .origin_i(org_y_q),
    .inv_i(inv_y_q), .axis_o(ax_y));
  tvfs_axis_map #(.N(GRID_D)) u_map_z (
    .clk_i, .en_i(en), .point_i(point_z_i), .origin_i(org_z_q),
    .inv_i(inv_z_q), .axis_o(ax_z));

  // Query sequencing: mapping valid chain, then eight corner reads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_v_q  <= '0;
      busy_q   <= 1'b0;
      corner_q <= '0;
    end else if (en) begin
      map_v_q <= {map_v_q[1:0], accept && (op_e'(op_i) == OP_QUERY)};
      if (accept && (op_e'(op_i) == OP_QUERY)) begin
        busy_q <= 1'b1;
      end else if (corner_q == 3'd7) begin
        busy_q   <= 1'b0;
        corner_q <= '0;
      end else if (map_v_q[2] || corner_q != 3'd0) begin
        corner_q <= corner_q + 3'd1;
      end
    end
  end

  // Hold the mapped axes for the corner phase.
  always_ff @(posedge clk_i) begin
    if (en && map_v_q[2]) begin
      hx_q <= ax_x; hy_q <= ax_y; hz_q <= ax_z;
    end
  end

  logic       active;
  axis_t      ux, uy, uz;
  assign active = map_v_q[2] || corner_q != 3'd0;
  assign ux = map_v_q[2] ? ax_x : hx_q;
  assign uy = map_v_q[2] ? ax_y : hy_q;
  assign uz = map_v_q[2] ? ax_z : hz_q;
  assign any_fail = ux.fail || uy.fail || uz.fail;
  assign cx = corner_q[2] ? ux.hi : ux.lo;
  assign cy = corner_q[1] ? uy.hi : uy.lo;
  assign cz = corner_q[0] ? uz.hi : uz.lo;
  assign lin = 32'(cx) + 32'(GRID_W) * 32'(cy) + 32'(GRID_W * GRID_H) * 32'(cz);

  assign ram_we   = accept && (op_e'(op_i) == OP_LOAD);
  assign ram_addr = ram_we ? voxel_index_i : lin[StoreAw-1:0];

  tvfs_ram #(.Width(VoxW), .Depth(StoreDepth)) u_store (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i({load_z_i, load_y_i, load_x_i}), .rdata_o(ram_rdata));

  // Control aligned with the registered RAM read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_v_q <= 1'b0;
    end else if (en) begin
      samp_v_q <= active;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      samp_ctl_q.corner <= corner_q;
      samp_ctl_q.last   <= corner_q == 3'd7;
      samp_ctl_q.fail   <= any_fail;
      if (map_v_q[2]) begin
        fwx_q <= ax_x.wgt; fwy_q <= ax_y.wgt; fwz_q <= ax_z.wgt;
      end
    end
  end

  // The RAM output does not freeze, so a stall must not break a read:
  // stalls only happen with a result held, and the corner phase runs
  // with en high except when the result register is full and stalled.
  tvfs_blend u_blend (
    .clk_i, .rst_ni, .en_i(en), .vld_i(samp_v_q), .ctl_i(samp_ctl_q),
    .fx_i(fwx_q), .fy_i(fwy_q), .fz_i(fwz_q), .vox_i(ram_rdata_h),
    .vld_o(blend_v), .flow_x_o, .flow_y_o, .flow_z_o, .failed_o);

  // Keep the read data steady while the pipeline is frozen.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1;
    end else begin
      en_q <= en;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_q) begin
      ram_hold_q <= ram_rdata;
    end
  end
  assign ram_rdata_h = en_q ? ram_rdata : ram_hold_q;

  assign out_valid_o = blend_v;

  // A load never starts while a query is in its corner phase.
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !ram_we) else $error("load during query");
  // Corners are walked only for an active query.
  a_corner_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (corner_q != 3'd0) |-> busy_q) else $error("corner without query");
  // A held result stays while the receiver stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
endmodule
`default_nettype wire

@@ sv/tvfs_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module tvfs_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // One access per cycle; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ sv/tvfs_axis_map.sv @@
// Three-stage pipeline that maps one coordinate to grid units: subtract,
// multiply, range check. Depends on tvfs_pkg.
`default_nettype none
module tvfs_axis_map #(
  parameter int unsigned N = 32
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [31:0]    point_i,
  input  wire logic [31:0]    origin_i,
  input  wire logic [31:0]    inv_i,
  output tvfs_pkg::axis_t     axis_o
);
  import tvfs_pkg::*;

  localparam logic [31:0] Last = 32'(N - 1);

  logic        neg_q;
  logic [32:0] mag_q;
  logic [31:0] inv_q;
  logic [32:0] d;
  logic [64:0] prod_d;
  logic [63:0] prod_q;
  logic        neg2_q;
  logic [31:0] ip;
  logic [31:0] fr;
  axis_t       ax_d;

  assign d = {point_i[31], point_i} - {origin_i[31], origin_i};

  // Stage one: magnitude of the offset from the origin.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= d[32];
      mag_q <= d[32] ? (33'd0 - d) : d;
      inv_q <= inv_i;
    end
  end

  // Stage two: exact Q32.32 product.
  assign prod_d = 65'(mag_q) * 65'(inv_q);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d[63:0];
      neg2_q <= neg_q;
    end
  end

  // Stage three: integer and fraction, range check and corner weight.
  assign ip = prod_q[63:32];
  assign fr = prod_q[31:0];
  always_comb begin
    ax_d.fail = (neg2_q && (prod_q != 64'd0)) || (ip > Last) ||
                ((ip == Last) && (fr != 32'd0));
    ax_d.lo   = ip[7:0];
    ax_d.hi   = (fr != 32'd0) ? ip[7:0] + 8'd1 : ip[7:0];
    ax_d.wgt  = fr[31:16];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      axis_o <= ax_d;
    end
  end
endmodule
`default_nettype wire

@@ sv/tvfs_blend.sv @@
// Blend pipeline: corner weight products, component products and the
// accumulation over eight corners with final rounding. Depends on tvfs_pkg.
`default_nettype none
module tvfs_blend (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 vld_i,
  input  wire tvfs_pkg::samp_ctl_t  ctl_i,
  input  wire logic [15:0]          fx_i,
  input  wire logic [15:0]          fy_i,
  input  wire logic [15:0]          fz_i,
  input  wire logic [47:0]          vox_i,
  output logic                      vld_o,
  output logic [15:0]               flow_x_o,
  output logic [15:0]               flow_y_o,
  output logic [15:0]               flow_z_o,
  output logic                      failed_o
);
  import tvfs_pkg::*;

  logic [16:0] wx;
  logic [16:0] wy;
  logic [16:0] wz;
  logic [33:0] wxy_q;
  logic [16:0] wz_q;
  logic        v1_q;
  samp_ctl_t   c1_q;
  logic [47:0] vox1_q;
  logic [50:0] w_q;
  logic        v2_q;
  samp_ctl_t   c2_q;
  logic [47:0] vox2_q;
  logic signed [67:0] p_q [3];
  logic        v3_q;
  samp_ctl_t   c3_q;
  logic signed [67:0] acc_q [3];
  logic signed [67:0] sum [3];
  logic [15:0] rnd [3];

  always_comb begin
    wx = ctl_i.corner[2] ? {1'b0, fx_i} : 17'h10000 - {1'b0, fx_i};
    wy = ctl_i.corner[1] ? {1'b0, fy_i} : 17'h10000 - {1'b0, fy_i};
    wz = ctl_i.corner[0] ? {1'b0, fz_i} : 17'h10000 - {1'b0, fz_i};
  end

  // Stage one: x by y weight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wxy_q  <= 34'(wx) * 34'(wy);
      wz_q   <= wz;
      c1_q   <= ctl_i;
      vox1_q <= vox_i;
    end
  end

  // Stage two: full corner weight (at most 2^48).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q    <= 51'(wxy_q) * 51'(wz_q);
      c2_q   <= c1_q;
      vox2_q <= vox1_q;
    end
  end

  // Stage three: weighted components.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        p_q[k] <= 68'(signed'(vox2_q[16*k +: 16])) * signed'({17'd0, w_q});
      end
      c3_q <= c2_q;
    end
  end

  // Stage four: accumulate eight corners, round on the last.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = ((c3_q.corner == 3'd0) ? 68'sd0 : acc_q[k]) + p_q[k];
      rnd[k] = 16'((sum[k] + (68'sd1 <<< 47)) >>> 48);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i && v3_q) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= sum[k];
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= v3_q && c3_q.last;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i && v3_q && c3_q.last) begin
      failed_o <= c3_q.fail;
      flow_x_o <= c3_q.fail ? 16'd0 : rnd[0];
      flow_y_o <= c3_q.fail ? 16'd0 : rnd[1];
      flow_z_o <= c3_q.fail ? 16'd0 : rnd[2];
    end
  end
endmodule
`default_nettype wire

@@ test/tb_trilinear_vector_field_sampler_unit.sv @@
// Testbench of the trilinear vector field sampler: voxel loads and point queries
// are checked against a predictor of the trilinear blend. Depends on tvfs_pkg
// and trilinear_vector_field_sampler_unit.
module tb_trilinear_vector_field_sampler_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tvfs_pkg::*;

  localparam int unsigned CycleLimit = 600000;

  typedef struct {
    logic [15:0] fx, fy, fz;
    logic        fail;
  } flow_t;

  // Predictor of the sampler with its own registers, voxel store and
  // queue of expected flow vectors.
  class flow_scoreboard;
    logic [31:0] origin[3];
    logic [31:0] inv_step[3];
    logic [47:0] voxels[int];
    flow_t       expected_flows[$];
    int          errors;

    function new();
      for (int a = 0; a < 3; a++) begin
        origin[a] = '0;
        inv_step[a] = 32'd65536;
      end
      errors = 0;
    endfunction

    function void set_reg(reg_e idx, logic [31:0] val);
      case (idx)
        REG_ORIGIN_X: origin[0] = val;
        REG_ORIGIN_Y: origin[1] = val;
        REG_ORIGIN_Z: origin[2] = val;
        REG_INV_X:    inv_step[0] = val;
        REG_INV_Y:    inv_step[1] = val;
        REG_INV_Z:    inv_step[2] = val;
        default: ;
      endcase
    endfunction

    // Grid mapping of one axis; returns 0 when the point is off the grid.
    function automatic bit map_axis(logic [31:0] pt, int a, output int lo, output int hi,
                                    output longint wgt);
      logic signed [32:0] d;
      logic [32:0]        mag;
      logic [64:0]        prod;
      logic [32:0]        ip;
      logic [31:0]        fr;
      d = $signed({pt[31], pt}) - $signed({origin[a][31], origin[a]});
      mag = d[32] ? -d : d;
      prod = {32'b0, mag} * {33'b0, inv_step[a]};
      ip = prod[64:32];
      fr = prod[31:0];
      lo = 0;
      hi = 0;
      wgt = 0;
      if (d[32] && prod != 0) return 0;
      if (ip > 33'(GridW - 1)) return 0;
      if (ip == 33'(GridW - 1) && fr != 0) return 0;
      lo = int'(ip);
      hi = (fr != 0) ? lo + 1 : lo;
      wgt = longint'(fr[31:16]);
      return 1;
    endfunction

    // Maps a query to its eight corner addresses and weights.
    function automatic bit corners(logic [31:0] pt[3], output int addr[8],
                                   output longint w[8]);
      int     lo[3], hi[3];
      longint f[3];
      int     c[3];
      longint wa[3];
      for (int a = 0; a < 3; a++)
        if (!map_axis(pt[a], a, lo[a], hi[a], f[a])) return 0;
      for (int k = 0; k < 8; k++) begin
        for (int a = 0; a < 3; a++) begin
          // Corner bit 2 picks x, bit 1 y, bit 0 z.
          c[a] = k[2 - a] ? hi[a] : lo[a];
          wa[a] = k[2 - a] ? f[a] : 65536 - f[a];
        end
        addr[k] = (c[0] + GridW * c[1] + GridW * GridH * c[2]) & (StoreDepth - 1);
        w[k] = wa[0] * wa[1] * wa[2];
      end
      return 1;
    endfunction

    // First unwritten corner of an on-grid query, or -1.
    function automatic int missing_corner(logic [31:0] pt[3]);
      int     addr[8];
      longint w[8];
      if (!corners(pt, addr, w)) return -1;
      foreach (addr[k])
        if (!voxels.exists(addr[k])) return addr[k];
      return -1;
    endfunction

    function void note_request(op_e op, logic [14:0] idx, logic [15:0] ld[3],
                               logic [31:0] pt[3]);
      int     addr[8];
      longint w[8];
      longint acc[3];
      flow_t  res;
      if (op == OP_LOAD) begin
        voxels[int'(idx)] = {ld[2], ld[1], ld[0]};
        return;
      end
      res = '{16'h0, 16'h0, 16'h0, 1'b1};
      if (corners(pt, addr, w)) begin
        acc = '{0, 0, 0};
        for (int k = 0; k < 8; k++)
          for (int a = 0; a < 3; a++)
            acc[a] += longint'($signed(voxels[addr[k]][16*a +: 16])) * w[k];
        // Round half up from Q8.56 to Q8.8.
        res.fx = 16'((acc[0] + (longint'(1) << 47)) >>> 48);
        res.fy = 16'((acc[1] + (longint'(1) << 47)) >>> 48);
        res.fz = 16'((acc[2] + (longint'(1) << 47)) >>> 48);
        res.fail = 1'b0;
      end
      expected_flows.push_back(res);
    endfunction

    function void check_flow(flow_t got);
      flow_t exp_f;
      if (expected_flows.size() == 0) begin
        $error("flow result with no query outstanding");
        errors++;
        return;
      end
      exp_f = expected_flows.pop_front();
      if (got.fx !== exp_f.fx) begin
        $error("flow_x expected %h actual %h", exp_f.fx, got.fx); errors++;
      end
      if (got.fy !== exp_f.fy) begin
        $error("flow_y expected %h actual %h", exp_f.fy, got.fy); errors++;
      end
      if (got.fz !== exp_f.fz) begin
        $error("flow_z expected %h actual %h", exp_f.fz, got.fz); errors++;
      end
      if (got.fail !== exp_f.fail) begin
        $error("failed expected %b actual %b", exp_f.fail, got.fail); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [14:0] voxel_index_i = '0;
  logic [15:0] load_x_i = '0, load_y_i = '0, load_z_i = '0;
  logic [31:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] flow_x_o, flow_y_o, flow_z_o;
  logic        failed_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  flow_scoreboard flows = new();
  int  cycles = 0;
  bit  hold_request = 1'b0;

  trilinear_vector_field_sampler_unit DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side: check each accepted flow vector.
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      flows.check_flow('{flow_x_o, flow_y_o, flow_z_o, failed_o});

  // Receiver stall pattern, with one long hold-off on request.
  always @(negedge clk_i) begin
    int mode, left, hold;
    if (hold_request && hold == 0) begin
      hold = 400;
      hold_request = 1'b0;
    end
    if (hold > 0) begin
      hold--;
      out_stall_i <= 1'b1;
    end else begin
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(8, 80);
      end
      left--;
      out_stall_i <= (mode == 0) ? 1'b0 : ($urandom_range(0, 9) < mode * 3);
    end
  end

  task automatic send_request(op_e op, logic [14:0] idx, logic [15:0] ld[3],
                              logic [31:0] pt[3]);
    in_valid_i <= 1'b1;
    op_i <= op;
    voxel_index_i <= idx;
    load_x_i <= ld[0];
    load_y_i <= ld[1];
    load_z_i <= ld[2];
    point_x_i <= pt[0];
    point_y_i <= pt[1];
    point_z_i <= pt[2];
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    flows.note_request(op, idx, ld, pt);
    @(negedge clk_i);
  endtask

  // Sends a query, first loading every corner it would read that is still unwritten.
  task automatic send_query(logic [31:0] pt[3]);
    int          miss;
    logic [15:0] ld[3];
    miss = flows.missing_corner(pt);
    while (miss >= 0) begin
      ld = '{16'($urandom), 16'($urandom), 16'($urandom)};
      send_request(OP_LOAD, 15'(miss), ld, pt);
      miss = flows.missing_corner(pt);
    end
    send_request(OP_QUERY, 15'($urandom), '{16'($urandom), 16'($urandom), 16'($urandom)},
                 pt);
  endtask

  task automatic send_load(int x, int y, int z, logic [15:0] ld[3]);
    logic [31:0] pt[3];
    pt = '{$urandom, $urandom, $urandom};
    send_request(OP_LOAD, 15'(x + GridW * y + GridW * GridH * z), ld, pt);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (flows.expected_flows.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    flows.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(logic [31:0] org[3], logic [31:0] inv[3]);
    write_reg(REG_ORIGIN_X, org[0]);
    write_reg(REG_ORIGIN_Y, org[1]);
    write_reg(REG_ORIGIN_Z, org[2]);
    write_reg(REG_INV_X, inv[0]);
    write_reg(REG_INV_Y, inv[1]);
    write_reg(REG_INV_Z, inv[2]);
  endtask

  // Point on one axis, mostly near the low corner of the grid.
  function automatic logic [31:0] pick_coord(int a);
    int     r;
    longint lim, d;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom;
    lim = ((r < 70 ? longint'(6) : longint'(34)) << 32) / flows.inv_step[a];
    if (lim > 32'h7fffffff) lim = 32'h7fffffff;
    if (lim < 4) lim = 4;
    d = longint'($urandom_range(0, int'(lim))) - lim / 16;
    if (r >= 92)
      d = (longint'($urandom_range(0, GridW - 1)) << 32) / flows.inv_step[a];
    return flows.origin[a] + 32'(d);
  endfunction

  // Random part of one setting: bursts of loads and queries with gaps.
  task automatic random_phase(int n);
    logic [31:0] pt[3];
    logic [15:0] ld[3];
    int          burst, k;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      for (k = 0; k < burst && n > 0; k++, n--) begin
        if ($urandom_range(0, 9) < 4) begin
          ld = '{16'($urandom), 16'($urandom), 16'($urandom)};
          if ($urandom_range(0, 9) == 0) ld = '{16'h8000, 16'h7fff, 16'h0000};
          if ($urandom_range(0, 9) < 7)
            send_load($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7), ld);
          else
            send_request(OP_LOAD, 15'($urandom), ld, '{$urandom, $urandom, $urandom});
        end else begin
          for (int a = 0; a < 3; a++) pt[a] = pick_coord(a);
          send_query(pt);
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    logic [15:0] ld[3];
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: unit spacing at the origin, field extremes and grid edges.
    ld = '{16'h7fff, 16'h8000, 16'h0001};
    send_load(0, 0, 0, ld);
    ld = '{16'h8000, 16'h7fff, 16'hffff};
    send_load(1, 0, 0, ld);
    ld = '{16'h1234, 16'hedcb, 16'h0100};
    send_load(GridW - 1, GridH - 1, GridD - 1, ld);
    send_query('{32'h0, 32'h0, 32'h0});
    send_query('{32'h0000_8000, 32'h0, 32'h0});
    send_query('{32'h0000_ffff, 32'h0, 32'h0});
    // Exactly on the last sample is inside, just past it is not.
    send_query('{32'h001f_0000, 32'h001f_0000, 32'h001f_0000});
    send_query('{32'h001f_0001, 32'h001f_0000, 32'h001f_0000});
    send_query('{32'h0020_0000, 32'h0, 32'h0});
    send_query('{32'hffff_ffff, 32'h0, 32'h0});
    send_query('{32'h8000_0000, 32'h7fff_ffff, 32'h0});
    send_query('{32'h0, 32'h0, 32'h8000_0000});
    send_query('{32'h0008_4000, 32'h0003_c000, 32'h0005_2000});
    send_request(OP_LOAD, 15'h7fff, '{16'h5555, 16'haaaa, 16'h0f0f},
                 '{32'h0, 32'h0, 32'h0});
    send_query('{32'h001e_8000, 32'h001e_8000, 32'h001e_8000});
    random_phase(200);

    // The block fills up while the receiver holds off, then fully drains.
    hold_request = 1'b1;
    random_phase(60);
    wait_drained();
    random_phase(80);
    wait_drained();

    // Half spacing on x and y, inverse step 1.5 on z, with a fractional negative origin.
    set_grid('{32'hfffd_8000, 32'hfffe_0000, 32'h0000_4000},
             '{32'h0002_0000, 32'h0002_0000, 32'h0001_8000});
    random_phase(200);
    wait_drained();

    // Extreme origins and steps.
    set_grid('{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000},
             '{32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff});
    send_query('{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000});
    send_query('{32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0001});
    random_phase(150);
    wait_drained();

    // Unit spacing on x and z, inverse step 0.75 on y, with random small x and y origins.
    set_grid('{32'($urandom_range(0, 65536 * 4)), 32'($urandom_range(0, 65536 * 4)), 32'h0},
             '{32'h0001_0000, 32'h0000_c000, 32'h0001_0000});
    random_phase(250);
    wait_drained();

    if (flows.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
